// ----- rtl/core/adlw_pkg.sv -----
// Shared types and constants for the wide Adler-32 checksum block.
`timescale 1ns / 1ps

package adlw_pkg;

   localparam int WORD_BYTES = 8;
   localparam int BYTE_W     = 8;
   localparam int DATA_W     = WORD_BYTES * BYTE_W;
   localparam int COUNT_W    = 4;
   localparam int PROD_W     = COUNT_W + BYTE_W;
   localparam int BYTES_W    = 11;
   localparam int WEIGHTED_W = 14;
   localparam int SUM_W      = 16;
   localparam int SEED_W     = 2 * SUM_W;
   localparam int A_TOT_W    = SUM_W + 1;
   localparam int B_TOT_W    = SUM_W + COUNT_W;

   localparam logic [SUM_W-1:0] ADLER_MOD   = 16'd65521;
   localparam logic [SUM_W-1:0] FOLD_FACTOR = 16'd15;
   localparam logic [SUM_W-1:0] RESET_A     = 16'd1;
   localparam logic [SUM_W-1:0] RESET_B     = 16'd0;

   typedef struct packed {
      logic [BYTES_W-1:0]    bytes_sum;
      logic [WEIGHTED_W-1:0] weighted_sum;
   } lane_sums_type;

endpackage

// ----- rtl/core/adlw_lane.sv -----
// One byte lane: masks the byte by the count and weights it by its distance from the end.
`timescale 1ns / 1ps

module adlw_lane import adlw_pkg::*; (
   input  logic [BYTE_W-1:0]  lane_byte,
   input  logic [COUNT_W-1:0] lane_idx,
   input  logic [COUNT_W-1:0] count,
   output lane_sums_type      lane_sums
);

   logic [COUNT_W-1:0] weight;
   logic [PROD_W-1:0]  product;

   always_comb begin
      weight  = (count > lane_idx) ? (count - lane_idx) : '0;
      product = PROD_W'(weight) * PROD_W'(lane_byte);
      lane_sums.bytes_sum    = (weight != '0) ? BYTES_W'(lane_byte) : '0;
      lane_sums.weighted_sum = WEIGHTED_W'(product);
   end

endmodule

// ----- rtl/core/adlw_merge.sv -----
// Merging stage: adds the byte and weighted sums of all lanes.
`timescale 1ns / 1ps

module adlw_merge import adlw_pkg::*; (
   input  lane_sums_type lane_sums [WORD_BYTES],
   output lane_sums_type item_sums
);

   always_comb begin
      item_sums = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         item_sums.bytes_sum    = item_sums.bytes_sum + lane_sums[i].bytes_sum;
         item_sums.weighted_sum = item_sums.weighted_sum + lane_sums[i].weighted_sum;
      end
   end

endmodule

// ----- rtl/core/adlw_update.sv -----
// Running-sum update: adds one transaction's sums and reduces both halves modulo 65521.
`timescale 1ns / 1ps

module adlw_update import adlw_pkg::*; (
   input  logic               first,
   input  logic [SEED_W-1:0]  seed,
   input  logic [SUM_W-1:0]   sum_a,
   input  logic [SUM_W-1:0]   sum_b,
   input  logic [COUNT_W-1:0] count,
   input  lane_sums_type      item_sums,
   output logic [SUM_W-1:0]   next_a,
   output logic [SUM_W-1:0]   next_b
);

   logic [SUM_W-1:0]   a_base;
   logic [SUM_W-1:0]   b_base;
   logic [A_TOT_W-1:0] a_tot;
   logic [B_TOT_W-1:0] b_tot;
   logic [A_TOT_W-1:0] b_fold;

   always_comb begin
      a_base = first ? seed[SUM_W-1:0] : sum_a;
      b_base = first ? seed[SEED_W-1:SUM_W] : sum_b;
      a_tot  = A_TOT_W'(a_base) + A_TOT_W'(item_sums.bytes_sum);
      b_tot  = B_TOT_W'(b_base) + B_TOT_W'(count) * B_TOT_W'(a_base)
               + B_TOT_W'(item_sums.weighted_sum);
      // 2^16 is congruent to 15, so the high bits fold back in at weight 15.
      b_fold = A_TOT_W'(b_tot[SUM_W-1:0])
               + A_TOT_W'(b_tot[B_TOT_W-1:SUM_W]) * A_TOT_W'(FOLD_FACTOR);
      next_a = (a_tot >= A_TOT_W'(ADLER_MOD)) ? SUM_W'(a_tot - A_TOT_W'(ADLER_MOD))
                                              : a_tot[SUM_W-1:0];
      next_b = (b_fold >= A_TOT_W'(ADLER_MOD)) ? SUM_W'(b_fold - A_TOT_W'(ADLER_MOD))
                                               : b_fold[SUM_W-1:0];
   end

endmodule

// ----- rtl/core/adler32_wide_checksum.sv -----
// Top level of the wide Adler-32 checksum: lane stage, merge, running sums and handshakes.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle while its output is not stalled;
// a word's sums are registered in the lane stage, then folded into the output's
// A and B registers. The first stage splits the word into byte lanes and merges
// their byte and weighted sums into a register. The second stage folds those
// sums into the running A and B values and reduces both modulo 65521 in the same
// cycle. That update loop on the 16-bit sums is what sets the rate. The lane
// stage still accepts one transaction while a finished result waits on a stalled
// output; the input stalls only when both stages are full. Byte counts above the
// number of lanes are saturated to it, and a count of zero adds nothing.

module adler32_wide_checksum import adlw_pkg::*; #(
   parameter int BYTES_PER_ITEM = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [DATA_W-1:0]  req_data_word,
   input  logic [COUNT_W-1:0] req_byte_count,
   input  logic               req_first,
   input  logic [SEED_W-1:0]  req_seed,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SEED_W-1:0]  rsp_checksum,
   output logic               rsp_is_last
);

   localparam int LANES = (BYTES_PER_ITEM > WORD_BYTES) ? WORD_BYTES : BYTES_PER_ITEM;

   logic               req_accept;
   logic               out_adv;
   logic               s1_move;
   logic               rsp_take;

   logic [COUNT_W-1:0] s1_count_in;
   lane_sums_type      lane_sums [WORD_BYTES];
   lane_sums_type      s1_sums_in;

   logic               s1_valid_ff,  s1_valid_in;
   lane_sums_type      s1_sums_ff;
   logic [COUNT_W-1:0] s1_count_ff;
   logic               s1_first_ff;
   logic [SEED_W-1:0]  s1_seed_ff;
   logic               s1_last_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff;
   logic [SUM_W-1:0]   sum_a_ff,     sum_a_in;
   logic [SUM_W-1:0]   sum_b_ff,     sum_b_in;

   assign out_adv    = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_adv;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_adv;
   assign req_accept = req_valid && !req_stall;

   assign s1_count_in = (req_byte_count > COUNT_W'(LANES)) ? COUNT_W'(LANES) : req_byte_count;

   for (genvar gi = 0; gi < WORD_BYTES; gi++) begin : g_lane
      if (gi < LANES) begin : g_used
         adlw_lane u_lane (
            .lane_byte (req_data_word[gi*BYTE_W +: BYTE_W]),
            .lane_idx  (COUNT_W'(gi)),
            .count     (s1_count_in),
            .lane_sums (lane_sums[gi])
         );
      end else begin : g_unused
         assign lane_sums[gi] = '0;
      end
   end

   adlw_merge u_merge (
      .lane_sums (lane_sums),
      .item_sums (s1_sums_in)
   );

   adlw_update u_update (
      .first     (s1_first_ff),
      .seed      (s1_seed_ff),
      .sum_a     (sum_a_ff),
      .sum_b     (sum_b_ff),
      .count     (s1_count_ff),
      .item_sums (s1_sums_ff),
      .next_a    (sum_a_in),
      .next_b    (sum_b_in)
   );

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_move ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_a_ff     <= RESET_A;
         sum_b_ff     <= RESET_B;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            sum_a_ff <= sum_a_in;
            sum_b_ff <= sum_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sums_ff  <= s1_sums_in;
         s1_count_ff <= s1_count_in;
         s1_first_ff <= req_first;
         s1_seed_ff  <= req_seed;
         s1_last_ff  <= req_last;
      end
      if (s1_move) begin
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = {sum_b_ff, sum_a_ff};
   assign rsp_is_last  = rsp_last_ff;

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (sum_a_ff < ADLER_MOD) && (sum_b_ff < ADLER_MOD))
      else $error("Running sums left unreduced.");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("Accepted transaction did not reach the lane stage.");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=>
         s1_valid_ff && $stable(s1_count_ff) && $stable(s1_sums_ff) && $stable(sum_a_ff))
      else $error("Lane stage or sums changed while the output was stalled.");

endmodule

// ----- tb/sv/tb_adler32_wide_checksum.sv -----
// Self-checking testbench for the wide Adler-32 checksum block.
`timescale 1ns / 1ps

module tb_adler32_wide_checksum;
   import adlw_pkg::*;

   localparam int ITEM_BYTES = 8;
   localparam int LANE_COUNT = (ITEM_BYTES < WORD_BYTES) ? ITEM_BYTES : WORD_BYTES;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 50000;
   localparam int RANDOM_ITEMS = 1200;

   typedef struct {
      logic [SEED_W-1:0] checksum;
      logic              is_last;
   } checksum_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [DATA_W-1:0]  req_data_word;
   logic [COUNT_W-1:0] req_byte_count;
   logic               req_first;
   logic [SEED_W-1:0]  req_seed;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [SEED_W-1:0]  rsp_checksum;
   logic               rsp_is_last;

   checksum_result_type expected_sums[$];
   logic [SUM_W-1:0] run_sum_a;
   logic [SUM_W-1:0] run_sum_b;
   int unsigned      mismatch_count;
   bit               tx_idle_on;
   bit               rx_idle_on;
   bit               hold_output;

   adler32_wide_checksum #(
      .BYTES_PER_ITEM(ITEM_BYTES)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_word (req_data_word),
      .req_byte_count(req_byte_count),
      .req_first     (req_first),
      .req_seed      (req_seed),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_checksum  (rsp_checksum),
      .rsp_is_last   (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_adler32_wide_checksum failed");
      $finish;
   end

   // Advances the running sums by one word and returns the new checksum.
   function automatic logic [SEED_W-1:0] adler_fold(input logic [DATA_W-1:0] word,
                                                    input logic [COUNT_W-1:0] count,
                                                    input logic first,
                                                    input logic [SEED_W-1:0] seed);
      int               lanes;
      longint unsigned  a;
      longint unsigned  b;
      longint unsigned  byte_total;
      longint unsigned  weighted;
      longint unsigned  c;
      lanes = (int'(count) > LANE_COUNT) ? LANE_COUNT : int'(count);
      a = first ? longint'(seed[SUM_W-1:0]) : longint'(run_sum_a);
      b = first ? longint'(seed[SEED_W-1:SUM_W]) : longint'(run_sum_b);
      byte_total = 0;
      weighted = 0;
      for (int i = 0; i < lanes; i++) begin
         c = longint'(word[8*i +: 8]);
         byte_total += c;
         weighted += longint'(lanes - i) * c;
      end
      b = b + longint'(lanes) * a + weighted;
      a = a + byte_total;
      run_sum_a = SUM_W'(a % longint'(ADLER_MOD));
      run_sum_b = SUM_W'(b % longint'(ADLER_MOD));
      return {run_sum_b, run_sum_a};
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!tx_idle_on || r < 70) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input logic [DATA_W-1:0] word, input logic [COUNT_W-1:0] count,
                            input logic first, input logic [SEED_W-1:0] seed,
                            input logic last);
      checksum_result_type expect_item;
      int unsigned      gap;
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= count;
      req_first      <= first;
      req_seed       <= seed;
      req_last       <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expect_item.checksum = adler_fold(word, count, first, seed);
      expect_item.is_last = last;
      expected_sums.push_back(expect_item);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic release_and_drain();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_sums.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // The first transaction after reset runs on the reset sums without a seed.
   task automatic test_reset_continuation();
      send_word(64'h0807_0605_0403_0201, 4'd8, 1'b0, 32'hDEAD_BEEF, 1'b0);
      send_word(64'h0, 4'd8, 1'b0, 32'h0, 1'b0);
      release_and_drain();
   endtask

   task automatic test_count_limits();
      send_word({DATA_W{1'b1}}, 4'd8, 1'b1, 32'h0000_0001, 1'b0);
      send_word({DATA_W{1'b1}}, 4'd0, 1'b0, 32'h0, 1'b0);
      send_word(64'h1122_3344_5566_7788, 4'd9, 1'b0, 32'h0, 1'b0);
      send_word({DATA_W{1'b1}}, 4'd15, 1'b0, 32'h0, 1'b0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b0, 32'h0, 1'b0);
      for (int n = 2; n < 8; n++) begin
         send_word(random_word(), COUNT_W'(n), 1'b0, 32'h0, 1'b0);
      end
      release_and_drain();
   endtask

   task automatic test_seed_loading();
      send_word({DATA_W{1'b1}}, 4'd8, 1'b1, 32'hFFF0_FFF0, 1'b0);
      send_word(64'h0, 4'd0, 1'b1, 32'hFFF1_FFF1, 1'b0);
      send_word({DATA_W{1'b1}}, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_word(64'h00AB_CDEF, 4'd3, 1'b0, 32'hDEAD_BEEF, 1'b0);
      send_word(64'h696B_6957, 4'd4, 1'b1, 32'h0000_0000, 1'b1);
      release_and_drain();
   endtask

   // A stream that spans a last flag, continued and then restarted.
   task automatic test_stream_boundaries();
      send_word(64'h6964_6570_696B_6957, 4'd8, 1'b1, 32'h0000_0001, 1'b0);
      send_word(64'h61, 4'd1, 1'b0, 32'h0, 1'b1);
      send_word(64'h7A, 4'd1, 1'b0, 32'h0, 1'b1);
      send_word(random_word(), 4'd8, 1'b1, 32'h0000_0001, 1'b1);
      release_and_drain();
   endtask

   task automatic test_random_streams();
      int          sent;
      int          len;
      logic [31:0] seed;
      logic [3:0]  count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               send_word(random_word(), COUNT_W'($urandom_range(0, 15)),
                         1'($urandom), $urandom, 1'($urandom));
            end
         end else begin
            len = $urandom_range(1, 24);
            seed = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0000_0001;
            for (int k = 0; k < len; k++) begin
               if (k == len - 1) begin
                  count = COUNT_W'($urandom_range(1, 8));
               end else if ($urandom_range(0, 4) == 0) begin
                  count = COUNT_W'($urandom_range(0, 15));
               end else begin
                  count = 4'd8;
               end
               send_word(random_word(), count, k == 0, seed, k == len - 1);
            end
         end
         sent += len;
      end
      release_and_drain();
   endtask

   task automatic test_back_to_back();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      for (int k = 0; k < 60; k++) begin
         send_word(random_word(), COUNT_W'($urandom_range(0, 15)), k % 16 == 0,
                   $urandom, k % 16 == 15);
      end
      release_and_drain();
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_backpressure();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_output = 1'b1;
      for (int k = 0; k < 40; k++) begin
         send_word(random_word(), 4'd8, k == 0, 32'h0000_0001, k == 39);
      end
      release_and_drain();
      rx_idle_on = 1'b1;
   endtask

   initial begin : receiver
      int unsigned r;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rx_idle_on) begin
            r = $urandom_range(0, 99);
            if (r >= 65) begin
               rsp_stall <= 1'b1;
               repeat ((r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40))
                  @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      checksum_result_type expect_item;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual checksum %h last %b",
                     $time, rsp_checksum, rsp_is_last);
            mismatch_count++;
         end else begin
            expect_item = expected_sums.pop_front();
            if (rsp_checksum !== expect_item.checksum) begin
               $display("%0t: checksum mismatch, expected %h, actual %h",
                        $time, expect_item.checksum, rsp_checksum);
               mismatch_count++;
            end
            if (rsp_is_last !== expect_item.is_last) begin
               $display("%0t: is_last mismatch, expected %b, actual %b",
                        $time, expect_item.is_last, rsp_is_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      hold_output = 1'b0;
      run_sum_a = RESET_A;
      run_sum_b = RESET_B;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_word  <= '0;
      req_byte_count <= '0;
      req_first      <= 1'b0;
      req_seed       <= '0;
      req_last       <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_continuation();
      test_count_limits();
      test_seed_loading();
      test_stream_boundaries();
      test_output_backpressure();
      test_random_streams();
      test_back_to_back();

      repeat (10) @(posedge clock);
      if (expected_sums.size() != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0",
                  $time, expected_sums.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb_adler32_wide_checksum passed");
      end else begin
         $display("tb_adler32_wide_checksum failed");
      end
      $finish;
   end

endmodule
